@@ rtl/isort_pkg.sv @@
package isort_pkg;

    localparam int unsigned VALUE_W = 32;

    typedef logic signed [VALUE_W-1:0] t_value;

    // One input transfer.
    typedef struct packed {
        t_value value;
        logic   last_item;
    } t_in_item;

    // One result transfer.
    typedef struct packed {
        t_value sorted_value;
        logic   final_res;
        logic   overflow;
    } t_out_item;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic ins;   // insert the broadcast value this cycle
        logic pop;   // shift the whole row one place toward cell 0
        logic desc;  // descending order for this insertion
    } t_cell_ctl;

endpackage

@@ rtl/isort_stream_if.sv @@
interface isort_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/isort_cell.sv @@
// One slot of the sorted row. Neighbor "lo" is the next lower index.
module isort_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  isort_pkg::t_cell_ctl i_ctl,
    input  isort_pkg::t_value   i_value,
    input  isort_pkg::t_value   i_lo_val,
    input  logic                i_lo_occ,
    input  logic                i_lo_move,
    input  isort_pkg::t_value   i_hi_val,
    input  logic                i_hi_occ,
    input  logic                i_move,
    output isort_pkg::t_value   o_val,
    output logic                o_occ,
    output logic                o_pass
);

    isort_pkg::t_value r_val;
    logic              r_occ;
    isort_pkg::t_value n_val;
    logic              n_occ;
    logic              goes_after;
    logic              put_here;

    // Stored value must sit above the new one (strict compare keeps arrival order).
    assign goes_after = i_ctl.desc ? (r_val < i_value) : (i_value < r_val);

    // Empty slots never stop the scan.
    assign o_pass = !r_occ || goes_after;

    // New value lands at the lowest moving slot, or at the first free slot.
    assign put_here = (i_move || (!r_occ && i_lo_occ)) && !i_lo_move;

    always_comb begin
        n_val = r_val;
        n_occ = r_occ;
        if (i_ctl.pop) begin
            n_val = i_hi_val;
            n_occ = i_hi_occ;
        end else if (i_ctl.ins) begin
            if (i_lo_move) begin
                n_val = i_lo_val;
                n_occ = 1'b1;
            end else if (put_here) begin
                n_val = i_value;
                n_occ = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    assign o_val = r_val;
    assign o_occ = r_occ;

endmodule

@@ rtl/insertion_sorter_core.sv @@
// Streaming insertion sorter for signed 32-bit values.
//
// Channels: i_in (sink) carries value and last_item; o_out (source) carries
// sorted_value, final_res and overflow. A transfer happens on a rising edge
// with valid and ready both high. i_cfg_we/i_cfg_data write the direction
// bit (0 ascending, 1 descending); write it only while the block is idle.
//
// Fill phase: one value is taken every cycle. Each cell of the row compares
// its stored value with the broadcast value and the row shifts open at the
// insertion point in the same cycle. Values past MAX_ELEMENTS are dropped and
// mark the set as overflowed.
//
// Emission: after the last_item transfer, i_in.ready drops. The row then
// shifts toward cell 0 one place per result into the output register; the
// first result is loaded once the state register is in S_EMIT, and the set
// streams at one result per cycle while o_out.ready stays high. A stalled
// receiver freezes the row; the output register holds its result. Once the
// result with final_res is loaded, i_in.ready rises again.
//
// Reset (synchronous, active low) empties the row and clears the internal flags and the output valid bit.
module insertion_sorter_core #(
    parameter int unsigned MAX_ELEMENTS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    isort_stream_if.sink   i_in,
    isort_stream_if.source o_out,
    input  logic           i_cfg_we,
    input  logic           i_cfg_data
);

    typedef enum logic {
        S_FILL,
        S_EMIT
    } t_state;

    t_state               r_state;
    logic                 r_desc;
    logic                 r_dropped;    // a value of the current set was lost
    logic                 r_emit_ovf;   // overflow flag for the set being emitted
    logic                 r_out_vld;
    isort_pkg::t_out_item r_out;

    isort_pkg::t_in_item  in_item;
    isort_pkg::t_cell_ctl ctl;
    isort_pkg::t_value    cell_val [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0] cell_occ;
    logic [MAX_ELEMENTS-1:0] cell_pass;
    logic [MAX_ELEMENTS-1:0] cell_move;
    logic                 in_xfer;
    logic                 out_free;
    logic                 row_full;
    logic                 pop;

    assign in_item  = i_in.data;
    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_free = !r_out_vld || o_out.ready;
    assign row_full = cell_occ[MAX_ELEMENTS-1];
    assign pop      = (r_state == S_EMIT) && out_free;

    assign i_in.ready = (r_state == S_FILL);

    assign ctl.ins  = in_xfer && !row_full;
    assign ctl.pop  = pop;
    assign ctl.desc = r_desc;

    // A stored value moves up only if it and every occupied value above it
    // must follow the new value; the scan stops at the first one that stays.
    genvar gi;
    generate
        for (gi = 0; gi < MAX_ELEMENTS; gi++) begin : g_cell
            assign cell_move[gi] = cell_occ[gi] && (&cell_pass[MAX_ELEMENTS-1:gi]);

            if (gi == 0) begin : g_first
                isort_cell u_cell (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_ctl     (ctl),
                    .i_value   (in_item.value),
                    .i_lo_val  (in_item.value),
                    .i_lo_occ  (1'b1),
                    .i_lo_move (1'b0),
                    .i_hi_val  (cell_val[gi+1]),
                    .i_hi_occ  (cell_occ[gi+1]),
                    .i_move    (cell_move[gi]),
                    .o_val     (cell_val[gi]),
                    .o_occ     (cell_occ[gi]),
                    .o_pass    (cell_pass[gi])
                );
            end else if (gi == MAX_ELEMENTS - 1) begin : g_last
                isort_cell u_cell (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_ctl     (ctl),
                    .i_value   (in_item.value),
                    .i_lo_val  (cell_val[gi-1]),
                    .i_lo_occ  (cell_occ[gi-1]),
                    .i_lo_move (cell_move[gi-1]),
                    .i_hi_val  (in_item.value),
                    .i_hi_occ  (1'b0),
                    .i_move    (cell_move[gi]),
                    .o_val     (cell_val[gi]),
                    .o_occ     (cell_occ[gi]),
                    .o_pass    (cell_pass[gi])
                );
            end else begin : g_mid
                isort_cell u_cell (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_ctl     (ctl),
                    .i_value   (in_item.value),
                    .i_lo_val  (cell_val[gi-1]),
                    .i_lo_occ  (cell_occ[gi-1]),
                    .i_lo_move (cell_move[gi-1]),
                    .i_hi_val  (cell_val[gi+1]),
                    .i_hi_occ  (cell_occ[gi+1]),
                    .i_move    (cell_move[gi]),
                    .o_val     (cell_val[gi]),
                    .o_occ     (cell_occ[gi]),
                    .o_pass    (cell_pass[gi])
                );
            end
        end
    endgenerate

    // Control, flags and the output register.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out.sorted_value <= cell_val[0];
            r_out.final_res    <= !cell_occ[1];
            r_out.overflow     <= r_emit_ovf;
        end
        if (!i_rst_n) begin
            r_state    <= S_FILL;
            r_desc     <= 1'b0;
            r_dropped  <= 1'b0;
            r_emit_ovf <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_desc <= i_cfg_data;
            end
            unique case (r_state)
                S_FILL: begin
                    if (in_xfer) begin
                        if (in_item.last_item) begin
                            r_emit_ovf <= r_dropped || row_full;
                            r_dropped  <= 1'b0;
                            r_state    <= S_EMIT;
                        end else if (row_full) begin
                            r_dropped <= 1'b1;
                        end
                    end
                end
                S_EMIT: begin
                    if (pop && !cell_occ[1]) begin
                        r_state <= S_FILL;
                    end
                end
                default: begin
                    r_state <= S_FILL;
                end
            endcase
            if (pop) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

endmodule

@@ rtl/isort_chk.sv @@
module isort_chk #(
    parameter int unsigned MAX_ELEMENTS = 64
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_in_last,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input isort_pkg::t_out_item i_out_data
);

    localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);

    logic             in_xfer;
    logic             out_xfer;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ovf;

    assign in_xfer  = i_in_valid && i_in_ready;
    assign out_xfer = i_out_valid && i_out_ready;

    // Results transferred so far in the current set and its overflow flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (out_xfer) begin
            r_cnt <= i_out_data.final_res ? '0 : r_cnt + CNT_W'(1);
            r_ovf <= i_out_data.overflow;
        end
    end

    // No input is taken right after a last_item transfer.
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_in_last |=> !i_in_ready)
        else $error("input taken right after last_item");

    // A set never exceeds the row.
    a_set_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer |-> r_cnt < CNT_W'(MAX_ELEMENTS))
        else $error("set longer than MAX_ELEMENTS");

    // Overflow is the same on every result of a set.
    a_ovf_const: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && (r_cnt != '0) |-> i_out_data.overflow == r_ovf)
        else $error("overflow changed within a set");

    // Stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

endmodule

bind insertion_sorter_core isort_chk #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
) u_isort_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.data.last_item),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
